### rtl/fixed_point_decimal_ascii_formatter_assert.svh
// Assertion macros used by the formatter's top-level RTL file.
`ifndef FIXED_POINT_DECIMAL_ASCII_FORMATTER_ASSERT_SVH
`define FIXED_POINT_DECIMAL_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define FPDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define FPDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fpda_pkg.sv
// Shared constants and types of the fixed-point decimal ASCII formatter.
package fpda_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int MAX_FRAC_DIGITS = 15;
  localparam int FRAC_W          = 4;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 4;

  localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int NCELLS     = (DEC_DIGITS > MAX_FRAC_DIGITS + 1) ?
                              DEC_DIGITS : MAX_FRAC_DIGITS + 1;
  localparam int POS_W      = $clog2(NCELLS);
  localparam int CNT_W      = $clog2(VALUE_WIDTH);
  localparam int CMP_W      = ((POS_W > FRAC_W) ? POS_W : FRAC_W) + 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONV,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     bit_in;
  } chain_ctrl_t;

endpackage

### rtl/fpda_if.sv
// Request channel interfaces for the formatter's input and result streams.
interface fpda_in_if;
  logic                               valid;
  logic                               ready;
  logic [fpda_pkg::VALUE_WIDTH-1:0]   value;
  logic [fpda_pkg::FRAC_W-1:0]        frac_digits;
  logic                               negative;

  modport source (output valid, output value, output frac_digits, output negative,
                  input ready);
  modport sink   (input valid, input value, input frac_digits, input negative,
                  output ready);
endinterface

interface fpda_out_if;
  logic                          valid;
  logic                          ready;
  logic [fpda_pkg::CHAR_W-1:0]   char_code;
  logic                          last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

### rtl/fpda_cell.sv
// One BCD digit cell: shift-and-add-three conversion step and digit shifting.
module fpda_cell (
  input  logic                            clk,
  input  fpda_pkg::cell_op_t              op,
  input  logic                            bit_in,
  input  logic [fpda_pkg::DIGIT_W-1:0]    digit_in,
  output logic                            bit_out,
  output logic [fpda_pkg::DIGIT_W-1:0]    digit
);

  logic [fpda_pkg::DIGIT_W-1:0] digit_r;
  logic [fpda_pkg::DIGIT_W-1:0] digit_nxt;
  logic [fpda_pkg::DIGIT_W-1:0] adj;

  assign adj     = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out = adj[fpda_pkg::DIGIT_W-1];
  assign digit   = digit_r;

  always_comb begin
    unique case (op)
      fpda_pkg::CELL_CLEAR: digit_nxt = '0;
      fpda_pkg::CELL_CONV:  digit_nxt = {adj[fpda_pkg::DIGIT_W-2:0], bit_in};
      fpda_pkg::CELL_SHIFT: digit_nxt = digit_in;
      default:              digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

### rtl/fpda_chain.sv
// Row of BCD digit cells, least significant cell first.
module fpda_chain (
  input  logic                            clk,
  input  fpda_pkg::chain_ctrl_t           ctrl,
  output logic [fpda_pkg::DIGIT_W-1:0]    top_digit
);

  logic [fpda_pkg::NCELLS-1:0]  carry;
  logic [fpda_pkg::DIGIT_W-1:0] digits [fpda_pkg::NCELLS];

  for (genvar i = 0; i < fpda_pkg::NCELLS; i++) begin : g_cell
    logic                         bit_in_w;
    logic [fpda_pkg::DIGIT_W-1:0] digit_in_w;

    if (i == 0) begin : g_first
      assign bit_in_w   = ctrl.bit_in;
      assign digit_in_w = '0;
    end else begin : g_rest
      assign bit_in_w   = carry[i-1];
      assign digit_in_w = digits[i-1];
    end

    fpda_cell u_cell (
      .clk      (clk),
      .op       (ctrl.op),
      .bit_in   (bit_in_w),
      .digit_in (digit_in_w),
      .bit_out  (carry[i]),
      .digit    (digits[i])
    );
  end

  assign top_digit = digits[fpda_pkg::NCELLS-1];

endmodule

### rtl/fixed_point_decimal_ascii_formatter.sv
// Top level: unsigned fixed-point value to decimal ASCII text, one character per beat.
//
//   Channel  Direction  Payload
//   in_if    sink       value, frac_digits, negative
//   out_if   source     char_code, last
//
// A request is converted bit-serially in the digit cell row, value MSB first.
// The row is then read MSB cell first, one of its 16 positions per cycle, each either a
// digit or a skipped leading zero; a digit waits while the result register is full. The
// sign and the point are each emitted in a state of their own.
// Reset clears the control state only; the digit cells are cleared on each request.
// A full result register that is not taken pauses emission; input is taken only when idle.
`include "fixed_point_decimal_ascii_formatter_assert.svh"

module fixed_point_decimal_ascii_formatter (
  input  logic              clk,
  input  logic              rst_n,
  fpda_in_if.sink           in_if,
  fpda_out_if.source        out_if
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT,
    ST_POINT
  } state_t;

  state_t                              state_r;
  logic [fpda_pkg::CNT_W-1:0]          cnt_r;
  logic [fpda_pkg::VALUE_WIDTH-1:0]    shreg_r;
  logic [fpda_pkg::FRAC_W-1:0]         frac_r;
  logic                                neg_r;
  logic [fpda_pkg::POS_W-1:0]          pos_r;
  logic                                seen_r;
  logic                                out_valid_r;
  logic [fpda_pkg::CHAR_W-1:0]         out_char_r;
  logic                                out_last_r;

  logic                                in_accept;
  logic                                out_free;
  logic                                out_load;
  logic                                must_emit;
  logic [fpda_pkg::DIGIT_W-1:0]        top_digit;
  logic [fpda_pkg::CMP_W-1:0]          pos_cmp;
  logic [fpda_pkg::CMP_W-1:0]          frac_cmp;
  logic [fpda_pkg::FRAC_W-1:0]         frac_sat;
  fpda_pkg::chain_ctrl_t               chain_ctrl;

  assign in_if.ready      = rst_n && (state_r == ST_IDLE);
  assign in_accept        = in_if.valid && in_if.ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.char_code = out_char_r;
  assign out_if.last      = out_last_r;
  assign out_free         = !out_valid_r || out_if.ready;
  assign out_load         = out_free && ((state_r == ST_SIGN) || (state_r == ST_POINT) ||
                                         (state_r == ST_DIGIT && must_emit));

  assign pos_cmp   = fpda_pkg::CMP_W'(pos_r);
  assign frac_cmp  = fpda_pkg::CMP_W'(frac_r);
  assign must_emit = seen_r || (top_digit != '0) || (pos_cmp <= frac_cmp);
  assign frac_sat  = (fpda_pkg::CMP_W'(in_if.frac_digits) >
                      fpda_pkg::CMP_W'(fpda_pkg::MAX_FRAC_DIGITS)) ?
                     fpda_pkg::FRAC_W'(fpda_pkg::MAX_FRAC_DIGITS) : in_if.frac_digits;

  always_comb begin
    chain_ctrl.bit_in = shreg_r[fpda_pkg::VALUE_WIDTH-1];
    if (in_accept) begin
      chain_ctrl.op = fpda_pkg::CELL_CLEAR;
    end else if (state_r == ST_CONV) begin
      chain_ctrl.op = fpda_pkg::CELL_CONV;
    end else if (state_r == ST_DIGIT && (!must_emit || out_free)) begin
      chain_ctrl.op = fpda_pkg::CELL_SHIFT;
    end else begin
      chain_ctrl.op = fpda_pkg::CELL_HOLD;
    end
  end

  fpda_chain u_chain (
    .clk       (clk),
    .ctrl      (chain_ctrl),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            shreg_r <= in_if.value;
            frac_r  <= frac_sat;
            neg_r   <= in_if.negative;
            cnt_r   <= '0;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          shreg_r <= {shreg_r[fpda_pkg::VALUE_WIDTH-2:0], 1'b0};
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == fpda_pkg::CNT_W'(fpda_pkg::VALUE_WIDTH - 1)) begin
            pos_r   <= fpda_pkg::POS_W'(fpda_pkg::NCELLS - 1);
            seen_r  <= 1'b0;
            state_r <= neg_r ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_char_r  <= fpda_pkg::CHAR_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (!must_emit) begin
            pos_r <= pos_r - 1'b1;
          end else if (out_free) begin
            out_char_r  <= fpda_pkg::CHAR_ZERO + fpda_pkg::CHAR_W'(top_digit);
            out_last_r  <= (pos_r == '0);
            seen_r      <= 1'b1;
            pos_r       <= pos_r - 1'b1;
            if (pos_r == '0) begin
              state_r <= ST_IDLE;
            end else if (pos_cmp == frac_cmp) begin
              state_r <= ST_POINT;
            end
          end
        end
        ST_POINT: begin
          if (out_free) begin
            out_char_r  <= fpda_pkg::CHAR_POINT;
            out_last_r  <= 1'b0;
            state_r     <= ST_DIGIT;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `FPDA_ASSERT_IMP(a_minus_not_last,
    out_if.valid && out_if.char_code == fpda_pkg::CHAR_MINUS, !out_if.last,
    "A minus sign was marked as the last character.")
  `FPDA_ASSERT_IMP(a_point_not_last,
    out_if.valid && out_if.char_code == fpda_pkg::CHAR_POINT, !out_if.last,
    "A decimal point was marked as the last character.")
  `FPDA_ASSERT_NEXT(a_accept_starts_conv,
    in_if.valid && in_if.ready, state_r == ST_CONV && cnt_r == '0,
    "An accepted request did not start the conversion.")

endmodule
